// ===== hw/rtl/bsa_pkg.sv =====
package bsa_pkg;

   localparam int unsigned NumClasses = 4;
   localparam int unsigned NumRegs    = 8;
   localparam int unsigned AddrWidth  = 64;
   localparam int unsigned WordWidth  = 32;
   localparam int unsigned ClassWidth = $clog2(NumClasses);
   localparam int unsigned IndexWidth = $clog2(NumRegs);

   // BAR word flag positions
   localparam int unsigned BitIo   = 0;
   localparam int unsigned Bit64   = 2;
   localparam int unsigned BitPref = 3;

   localparam logic [AddrWidth-1:0] LowNibbleClear = ~64'hF;
   localparam logic [WordWidth-1:0] UpperOnes      = '1;

   typedef enum logic [1:0] {
      STATUS_ASSIGNED = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_NO_ROOM  = 2'd2
   } status_type;

   typedef enum logic [ClassWidth-1:0] {
      CLASS_IO   = 2'd0,
      CLASS_NP32 = 2'd1,
      CLASS_P32  = 2'd2,
      CLASS_P64  = 2'd3
   } bar_class_type;

   // Register index: bit 0 selects limit over base, upper bits select the class
   localparam int unsigned RegLimitBit = 0;

   typedef struct packed {
      logic                 empty;
      bar_class_type        bar_class;
      logic [AddrWidth-1:0] size;
      logic [AddrWidth-1:0] align_mask;
   } bar_item_type;

   typedef struct packed {
      status_type           status;
      bar_class_type        bar_class;
      logic [AddrWidth-1:0] granted_address;
      logic [AddrWidth-1:0] region_size;
      logic                 takes_two_slots;
   } bar_result_type;

endpackage

// ===== hw/rtl/bar_sizing_allocator.sv =====
// Channel  Ports                                         Direction  Handshake
// req      req_bar_word, req_probe_low, req_probe_high   in         req_valid / req_ready
// rsp      rsp_status, rsp_bar_class, rsp_granted_address,
//          rsp_region_size, rsp_takes_two_slots          out        rsp_valid / rsp_ready
// csr      csr_index, csr_write_data                     in         csr_write_enable
//
// One BAR per cycle while rsp is not stalled. On a req transfer the BAR is
// decoded into an input register, then the round-up, end add and limit compare
// on that class's pointer run into the result register, where the pointer
// update also lands and rsp_valid rises. Synchronous reset clears pointers,
// limits and both valid flags. A stalled rsp holds its result; one further BAR
// may wait in the input register meanwhile.
module bar_sizing_allocator
   import bsa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [WordWidth-1:0]  req_bar_word,
   input  logic [WordWidth-1:0]  req_probe_low,
   input  logic [WordWidth-1:0]  req_probe_high,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_status,
   output logic [ClassWidth-1:0] rsp_bar_class,
   output logic [AddrWidth-1:0]  rsp_granted_address,
   output logic [AddrWidth-1:0]  rsp_region_size,
   output logic                  rsp_takes_two_slots,
   input  logic                  csr_write_enable,
   input  logic [IndexWidth-1:0] csr_index,
   input  logic [AddrWidth-1:0]  csr_write_data
);

   bar_item_type   decoded;
   bar_item_type   item_ff;
   bar_item_type   item_in;
   logic           item_valid_ff;
   logic           item_valid_in;
   bar_result_type result;
   bar_result_type result_ff;
   bar_result_type result_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           advance;
   logic           out_free;

   bsa_decode u_decode (
      .bar_word   (req_bar_word),
      .probe_low  (req_probe_low),
      .probe_high (req_probe_high),
      .item       (decoded)
   );

   bsa_alloc u_alloc (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .item             (item_ff),
      .commit           (advance),
      .result           (result)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = item_valid_ff && out_free;
   assign req_ready = !item_valid_ff || advance;

   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff;
      result_in     = result_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (advance) begin
         result_in     = result;
         rsp_valid_in  = 1'b1;
         item_valid_in = 1'b0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         item_in       = decoded;
         item_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload only
   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      result_ff <= result_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = result_ff.status;
   assign rsp_bar_class       = result_ff.bar_class;
   assign rsp_granted_address = result_ff.granted_address;
   assign rsp_region_size     = result_ff.region_size;
   assign rsp_takes_two_slots = result_ff.takes_two_slots;

   property p_empty_clean;
      @(posedge clock) disable iff (reset)
         rsp_valid_ff && (result_ff.status == STATUS_EMPTY) |->
            (rsp_granted_address == '0) && (rsp_region_size == '0) && !rsp_takes_two_slots;
   endproperty
   a_empty_clean: assert property (p_empty_clean)
      else $error("empty BAR result carries data");

   property p_no_room_zero;
      @(posedge clock) disable iff (reset)
         rsp_valid_ff && (result_ff.status == STATUS_NO_ROOM) |-> (rsp_granted_address == '0);
   endproperty
   a_no_room_zero: assert property (p_no_room_zero)
      else $error("no-room result carries an address");

   property p_two_slots;
      @(posedge clock) disable iff (reset)
         rsp_valid_ff && (result_ff.status != STATUS_EMPTY) |->
            (rsp_takes_two_slots == (result_ff.bar_class == CLASS_P64));
   endproperty
   a_two_slots: assert property (p_two_slots)
      else $error("two-slot flag disagrees with class");

   property p_advance_fills_rsp;
      @(posedge clock) disable iff (reset)
         advance |=> rsp_valid_ff;
   endproperty
   a_advance_fills_rsp: assert property (p_advance_fills_rsp)
      else $error("result lost on advance");

endmodule

// ===== hw/rtl/bsa_decode.sv =====
module bsa_decode
   import bsa_pkg::*;
(
   input  logic [WordWidth-1:0] bar_word,
   input  logic [WordWidth-1:0] probe_low,
   input  logic [WordWidth-1:0] probe_high,
   output bar_item_type         item
);

   bar_class_type        bar_class;
   logic [AddrWidth-1:0] probe;
   logic [AddrWidth-1:0] probe_dec;
   logic                 empty;

   always_comb begin
      if (bar_word[BitIo]) begin
         bar_class = CLASS_IO;
      end else if (bar_word[Bit64]) begin
         bar_class = CLASS_P64;
      end else if (bar_word[BitPref]) begin
         bar_class = CLASS_P32;
      end else begin
         bar_class = CLASS_NP32;
      end
   end

   assign empty     = (bar_word == '0);
   assign probe     = ((bar_class == CLASS_P64) ? {probe_high, probe_low}
                                                : {UpperOnes, probe_low}) & LowNibbleClear;
   assign probe_dec = probe - AddrWidth'(1);

   always_comb begin
      item = '0;
      if (!empty) begin
         item.bar_class = bar_class;
         item.size      = ~probe + AddrWidth'(1);
         // size - 1 is ~probe, so the mask below the lowest set bit needs no chain
         item.align_mask = (probe == '0) ? '0 : (~probe & probe_dec);
      end
      item.empty = empty;
   end

endmodule

// ===== hw/rtl/bsa_alloc.sv =====
module bsa_alloc
   import bsa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [IndexWidth-1:0] csr_index,
   input  logic [AddrWidth-1:0]  csr_write_data,
   input  bar_item_type          item,
   input  logic                  commit,
   output bar_result_type        result
);

   logic [AddrWidth-1:0] ptr_ff   [NumClasses];
   logic [AddrWidth-1:0] ptr_in   [NumClasses];
   logic [AddrWidth-1:0] limit_ff [NumClasses];
   logic [AddrWidth-1:0] limit_in [NumClasses];

   logic [AddrWidth-1:0] ptr;
   logic [AddrWidth-1:0] limit;
   logic [AddrWidth:0]   bumped;
   logic [AddrWidth-1:0] aligned;
   logic [AddrWidth:0]   region_end;
   logic                 round_over;
   logic                 fits;
   logic [ClassWidth-1:0] cfg_class;

   assign ptr        = ptr_ff[item.bar_class];
   assign limit      = limit_ff[item.bar_class];
   assign bumped     = {1'b0, ptr} + {1'b0, item.align_mask};
   assign round_over = bumped[AddrWidth];
   assign aligned    = bumped[AddrWidth-1:0] & ~item.align_mask;
   assign region_end = {1'b0, aligned} + {1'b0, item.size};
   assign fits       = !region_end[AddrWidth] && (region_end[AddrWidth-1:0] < limit);
   assign cfg_class  = csr_index[IndexWidth-1:1];

   always_comb begin
      result.bar_class       = item.bar_class;
      result.region_size     = item.size;
      result.takes_two_slots = !item.empty && (item.bar_class == CLASS_P64);
      result.granted_address = '0;
      if (item.empty) begin
         result.status = STATUS_EMPTY;
      end else if (round_over || !fits) begin
         result.status = STATUS_NO_ROOM;
      end else begin
         result.status          = STATUS_ASSIGNED;
         result.granted_address = aligned;
      end
   end

   always_comb begin
      ptr_in   = ptr_ff;
      limit_in = limit_ff;
      if (csr_write_enable) begin
         if (csr_index[RegLimitBit]) begin
            limit_in[cfg_class] = csr_write_data;
         end else begin
            ptr_in[cfg_class] = csr_write_data;
         end
      end else if (commit && !item.empty && !round_over) begin
         // keep the rounded pointer even when the region does not fit
         ptr_in[item.bar_class] = fits ? region_end[AddrWidth-1:0] : aligned;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumClasses; i++) begin
            ptr_ff[i]   <= '0;
            limit_ff[i] <= '0;
         end
      end else begin
         ptr_ff   <= ptr_in;
         limit_ff <= limit_in;
      end
   end

endmodule
